// ----- rtl/escaped_line_frame_receiver_top_assert.svh -----
// Assertion macros for the escaped line frame receiver top level.
`ifndef ESCAPED_LINE_FRAME_RECEIVER_TOP_ASSERT_SVH
`define ESCAPED_LINE_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ELFR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ELFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/elfr_pkg.sv -----
// Shared types and constants for the escaped line frame receiver.
package elfr_pkg;

   localparam int OP_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 7;
   localparam int LENGTH_W   = 7;
   localparam int NUM_BANKS  = 4;
   localparam int BANK_SEL_W = 2;
   localparam int NUM_SLOTS  = 3;

   localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
   localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
   localparam logic [OP_W-1:0] OP_READ    = 2'd2;

   localparam logic [BYTE_W-1:0] CH_AT        = 8'h40;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LOWER_N   = 8'h6E;
   localparam logic [BYTE_W-1:0] CH_LOWER_R   = 8'h72;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [BYTE_W-1:0]  rx_byte;
      logic [INDEX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic                frame_ready;
      logic [LENGTH_W-1:0] frame_length;
      logic [BYTE_W-1:0]   read_data;
      logic                byte_dropped;
   } rsp_type;

endpackage

// ----- rtl/elfr_if.sv -----
// Valid/ready word channels for requests and responses.
interface elfr_req_if;
   import elfr_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface elfr_rsp_if;
   import elfr_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/elfr_ram.sv -----
// Generic single-port-write RAM with registered read.
module elfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/escaped_line_frame_receiver_top.sv -----
// Top level of the escaped line frame receiver.
//
// channel    dir  handshake    word contents
// req_chan   in   valid/ready  operation, rx_byte, read_index
// rsp_chan   out  valid/ready  frame_ready, frame_length, read_data, byte_dropped
//
// One request word per cycle sustained while responses are taken; its response passes through
// the bank read register, then the output register.
// Frame state updates in the accepting cycle; the store is four interleaved banks so the
// up to three consecutive bytes one word writes land in different banks.
// Synchronous reset clears control state and per-entry valid bits directly; no sweep.
// Stalls: two response words can wait; req_chan.ready drops only when both are held.
`include "escaped_line_frame_receiver_top_assert.svh"

module escaped_line_frame_receiver_top #(
   parameter int STORE_DEPTH = 128
) (
   input logic        clock,
   input logic        reset,
   elfr_req_if.sink   req_chan,
   elfr_rsp_if.source rsp_chan
);
   import elfr_pkg::*;

   localparam int PW = $clog2(STORE_DEPTH);
   localparam int EW = (PW > LENGTH_W) ? PW : LENGTH_W;
   localparam logic [PW-1:0] LAST = PW'(STORE_DEPTH - 1);
   localparam int BANK_DEPTH = (STORE_DEPTH + NUM_BANKS - 1) / NUM_BANKS;
   localparam int BAW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   // frame state
   logic                   rcv_ff, rcv_in;
   logic                   esc_ff, esc_in;
   logic                   rdy_ff, rdy_in;
   logic [PW-1:0]          wp_ff, wp_in;
   logic [STORE_DEPTH-1:0] valid_ff;

   // response pipeline
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_ready_ff;
   logic [LENGTH_W-1:0]   s1_len_ff;
   logic                  s1_drop_ff;
   logic                  s1_hit_ff;
   logic [BANK_SEL_W-1:0] s1_bank_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   logic          accept, accept_ready, s1_advance;
   req_type       req;
   logic [OP_W-1:0]   req_op;
   logic [BYTE_W-1:0] rx;

   // byte write slots at consecutive positions
   logic [NUM_SLOTS-1:0] slot_en;
   logic [PW-1:0]        slot_addr [NUM_SLOTS];
   logic [BYTE_W-1:0]    slot_data [NUM_SLOTS];
   logic [PW-1:0]        pos;
   logic [1:0]           n;
   logic                 done, fin, dropped;

   logic                  bank_we    [NUM_BANKS];
   logic [BAW-1:0]        bank_waddr [NUM_BANKS];
   logic [BYTE_W-1:0]     bank_wdata [NUM_BANKS];
   logic [BYTE_W-1:0]     bank_rdata [NUM_BANKS];

   logic [EW-1:0] ridx_ext, wp_ext;
   logic [PW-1:0] ridx;
   logic [BAW-1:0] rd_row;
   logic          in_range, hit;

   assign req    = req_chan.payload;
   assign req_op = req.operation;
   assign rx     = req.rx_byte;

   assign s1_advance   = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign accept_ready = !s1_valid_ff || s1_advance;
   assign accept       = req_chan.valid && accept_ready;
   assign req_chan.ready = accept_ready;

   always_comb begin
      rcv_in  = rcv_ff;
      esc_in  = esc_ff;
      rdy_in  = rdy_ff;
      wp_in   = wp_ff;
      dropped = 1'b0;
      slot_en = '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         slot_addr[k] = '0;
         slot_data[k] = '0;
      end
      pos  = wp_ff;
      n    = '0;
      done = 1'b0;
      fin  = 1'b0;
      if (accept) begin
         case (req_op)
            OP_RECEIVE: begin
               if (rdy_ff) begin
                  dropped = 1'b1;
               end else if (!rcv_ff) begin
                  rcv_in = 1'b1;
                  wp_in  = '0;
                  if (rx != CH_AT) begin
                     slot_en[0]   = 1'b1;
                     slot_addr[0] = '0;
                     slot_data[0] = rx;
                     wp_in        = PW'(1);
                  end
               end else begin
                  if (esc_ff) begin
                     esc_in = 1'b0;
                     if (rx == CH_LOWER_N || rx == CH_LOWER_R) begin
                        fin  = 1'b1;
                        done = 1'b1;
                     end else if (pos < LAST) begin
                        slot_en[n]   = 1'b1;
                        slot_addr[n] = pos;
                        slot_data[n] = CH_BACKSLASH;
                        n            = n + 2'd1;
                        pos          = pos + 1'b1;
                     end
                  end
                  if (!done) begin
                     if (rx == CH_BACKSLASH) begin
                        esc_in = 1'b1;
                     end else if (rx == CH_LF || rx == CH_CR) begin
                        fin = 1'b1;
                     end else begin
                        if (pos < LAST) begin
                           slot_en[n]   = 1'b1;
                           slot_addr[n] = pos;
                           slot_data[n] = rx;
                           n            = n + 2'd1;
                           pos          = pos + 1'b1;
                        end
                        if (pos >= LAST) begin
                           fin = 1'b1;
                        end
                     end
                  end
                  if (fin) begin
                     slot_en[n]   = 1'b1;
                     slot_addr[n] = pos;
                     slot_data[n] = '0;
                     rcv_in       = 1'b0;
                     rdy_in       = 1'b1;
                  end
                  wp_in = pos;
               end
            end
            OP_CONSUME: rdy_in = 1'b0;
            default: ;
         endcase
      end
   end

   // route slots to banks by the low address bits
   always_comb begin
      for (int j = 0; j < NUM_BANKS; j++) begin
         bank_we[j]    = 1'b0;
         bank_waddr[j] = '0;
         bank_wdata[j] = '0;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            if (slot_en[k] && slot_addr[k][BANK_SEL_W-1:0] == BANK_SEL_W'(j)) begin
               bank_we[j]    = 1'b1;
               bank_waddr[j] = BAW'(slot_addr[k] >> BANK_SEL_W);
               bank_wdata[j] = slot_data[k];
            end
         end
      end
   end

   assign ridx_ext = EW'(req.read_index);
   assign ridx     = ridx_ext[PW-1:0];
   assign rd_row   = BAW'(ridx >> BANK_SEL_W);
   assign in_range = int'(req.read_index) < STORE_DEPTH;
   assign hit      = (req_op == OP_READ) && in_range && valid_ff[ridx];
   assign wp_ext   = EW'(wp_in);

   for (genvar j = 0; j < NUM_BANKS; j++) begin : g_bank
      elfr_ram #(
         .WIDTH(BYTE_W),
         .DEPTH(BANK_DEPTH)
      ) u_bank (
         .clock  (clock),
         .wr_en  (bank_we[j]),
         .wr_addr(bank_waddr[j]),
         .wr_data(bank_wdata[j]),
         .rd_en  (accept),
         .rd_addr(rd_row),
         .rd_data(bank_rdata[j])
      );
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_advance);
   assign out_valid_in = s1_advance || (out_valid_ff && !rsp_chan.ready);

   always_comb begin
      out_in.frame_ready  = s1_ready_ff;
      out_in.frame_length = s1_len_ff;
      out_in.read_data    = s1_hit_ff ? bank_rdata[s1_bank_ff] : '0;
      out_in.byte_dropped = s1_drop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcv_ff       <= 1'b0;
         esc_ff       <= 1'b0;
         rdy_ff       <= 1'b0;
         wp_ff        <= '0;
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rcv_ff       <= rcv_in;
         esc_ff       <= esc_in;
         rdy_ff       <= rdy_in;
         wp_ff        <= wp_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            if (slot_en[k]) begin
               valid_ff[slot_addr[k]] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ready_ff <= rdy_in;
         s1_len_ff   <= wp_ext[LENGTH_W-1:0];
         s1_drop_ff  <= dropped;
         s1_hit_ff   <= hit;
         s1_bank_ff  <= ridx[BANK_SEL_W-1:0];
      end
      if (s1_advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   `ELFR_ASSERT_IMPLY(a_ready_idle, rdy_ff, !rcv_ff, "frame ready while still receiving")
   `ELFR_ASSERT_IMPLY(a_escape_in_frame, esc_ff, rcv_ff, "escape pending outside a frame")
   `ELFR_ASSERT_IMPLY(a_position_bound, 1'b1, wp_ff <= LAST, "write position past last slot")
   `ELFR_ASSERT_NEXT(a_drop_holds, accept && req_op == OP_RECEIVE && rdy_ff, rdy_ff && $stable(wp_ff), "dropped word changed frame state")

endmodule

// ----- dv/escaped_line_frame_receiver_top_tb.sv -----
// Self-checking testbench for the escaped line frame receiver top level.
module escaped_line_frame_receiver_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import elfr_pkg::*;

   localparam int                DEPTH       = 128;
   localparam logic [6:0]        FULL_POS    = 7'(DEPTH - 1);
   localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
   localparam int                IDLE_LIMIT  = 3000;
   localparam int                HOLD_CYCLES = 300;
   localparam int                WORD_TARGET = 1300;

   typedef struct {
      req_type word;
      bit      drain_first;
   } pending_word;

   logic clock;
   logic reset;

   elfr_req_if req_chan();
   elfr_rsp_if rsp_chan();

   escaped_line_frame_receiver_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // frame tracking state
   logic       rx_active;
   logic       esc_held;
   logic       frame_done;
   logic [6:0] wr_pos;
   logic [7:0] frame_mem [DEPTH];

   pending_word pending_q[$];
   rsp_type     expected_status_q[$];

   int mismatches;
   int words_sent;
   int status_seen;
   int effective_items;
   int frames_closed;
   int frames_filled;
   int bytes_dropped;
   int reads_done;
   int idle_cycles;

   // driver state
   pending_word next_item;
   int          gap_left;
   int          burst_left;

   // receiver state
   int         holdoff_left;
   bit         holdoff_done;
   int         rsp_taken;
   int         mode;
   int         mode_left;
   logic [7:0] stall_pattern;
   logic       rdy;

   always #4 clock = ~clock;

   function void clear_frame_state();
      rx_active  = 1'b0;
      esc_held   = 1'b0;
      frame_done = 1'b0;
      wr_pos     = '0;
      for (int i = 0; i < DEPTH; i++) frame_mem[i] = '0;
   endfunction

   function void close_frame();
      rx_active           = 1'b0;
      frame_mem[wr_pos]   = '0;
      frame_done          = 1'b1;
      frames_closed++;
   endfunction

   function void append_byte(logic [7:0] b);
      if (wr_pos < FULL_POS) begin
         frame_mem[wr_pos] = b;
         wr_pos++;
      end
   endfunction

   function void absorb_byte(logic [7:0] b);
      if (!rx_active) begin
         rx_active = 1'b1;
         wr_pos    = '0;
         if (b != CH_AT) append_byte(b);
         return;
      end
      if (esc_held) begin
         esc_held = 1'b0;
         if (b == CH_LOWER_N || b == CH_LOWER_R) begin
            close_frame();
            return;
         end
         append_byte(CH_BACKSLASH);
      end
      if (b == CH_BACKSLASH) begin
         esc_held = 1'b1;
      end else if (b == CH_LF || b == CH_CR) begin
         close_frame();
      end else begin
         append_byte(b);
         if (wr_pos >= FULL_POS) begin
            frames_filled++;
            close_frame();
         end
      end
   endfunction

   function rsp_type apply_word(req_type w);
      rsp_type s;
      s = '0;
      case (w.operation)
         OP_RECEIVE: begin
            if (frame_done) begin
               s.byte_dropped = 1'b1;
               bytes_dropped++;
            end else begin
               absorb_byte(w.rx_byte);
            end
         end
         OP_CONSUME: frame_done = 1'b0;
         OP_READ: begin
            s.read_data = frame_mem[w.read_index];
            reads_done++;
         end
         default: ;
      endcase
      s.frame_ready  = frame_done;
      s.frame_length = wr_pos;
      return s;
   endfunction

   function void push_word(logic [OP_W-1:0] op, logic [7:0] b, logic [6:0] idx,
                           bit drain, bit counts);
      pending_word p;
      p.word.operation  = op;
      p.word.rx_byte    = b;
      p.word.read_index = idx;
      p.drain_first     = drain;
      pending_q.push_back(p);
      if (counts) effective_items++;
   endfunction

   function logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == CH_LF || b == CH_CR || b == CH_BACKSLASH);
      return b;
   endfunction

   function logic [7:0] escape_follower();
      logic [7:0] b;
      do b = plain_byte();
      while (b == CH_LOWER_N || b == CH_LOWER_R);
      return b;
   endfunction

   // start byte, len body items, then the chosen terminator (4 = none)
   function void push_frame(int len, int end_kind, int esc_rate);
      push_word(OP_RECEIVE, ($urandom_range(0, 5) == 0) ? CH_AT : plain_byte(), '0, 0, 1);
      for (int i = 0; i < len; i++) begin
         if (esc_rate != 0 && $urandom_range(1, esc_rate) == 1) begin
            push_word(OP_RECEIVE, CH_BACKSLASH, 7'($urandom), 0, 1);
            push_word(OP_RECEIVE, ($urandom_range(0, 4) == 0) ? CH_BACKSLASH
                                                              : escape_follower(),
                      7'($urandom), 0, 1);
         end else begin
            push_word(OP_RECEIVE, plain_byte(), 7'($urandom), 0, 1);
         end
      end
      case (end_kind)
         0: push_word(OP_RECEIVE, CH_LF, 7'($urandom), 0, 1);
         1: push_word(OP_RECEIVE, CH_CR, 7'($urandom), 0, 1);
         2, 3: begin
            push_word(OP_RECEIVE, CH_BACKSLASH, 7'($urandom), 0, 1);
            push_word(OP_RECEIVE, (end_kind == 2) ? CH_LOWER_N : CH_LOWER_R,
                      7'($urandom), 0, 1);
         end
         default: ;
      endcase
   endfunction

   // sender: bursts with random gaps, holds the word while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.payload <= '0;
         gap_left   = 0;
         burst_left = $urandom_range(1, 40);
         clear_frame_state();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_status_q.push_back(apply_word(req_chan.payload));
            words_sent++;
         end
         if (req_chan.valid && !req_chan.ready) begin
         end else if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_q.size() > 0 &&
                      !(pending_q[0].drain_first && expected_status_q.size() > 0)) begin
            next_item = pending_q.pop_front();
            req_chan.valid   <= 1'b1;
            req_chan.payload <= next_item.word;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver: stall modes, plus one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         holdoff_left = 0;
         holdoff_done = 1'b0;
         rsp_taken    = 0;
         mode_left    = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) rsp_taken++;
         if (!holdoff_done && rsp_taken >= 500) begin
            holdoff_left = HOLD_CYCLES;
            holdoff_done = 1'b1;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rdy = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode          = $urandom_range(0, 2);
               mode_left     = $urandom_range(20, 80);
               stall_pattern = 8'($urandom);
            end
            mode_left--;
            case (mode)
               0: rdy = 1'b1;
               1: rdy = ($urandom_range(0, 3) != 0);
               default: begin
                  rdy           = stall_pattern[0];
                  stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
               end
            endcase
         end
         rsp_chan.ready <= rdy;
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         status_seen++;
         if (expected_status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word %0d: ready=%0b len=%0d data=%02h drop=%0b",
                        status_seen, rsp_chan.payload.frame_ready,
                        rsp_chan.payload.frame_length, rsp_chan.payload.read_data,
                        rsp_chan.payload.byte_dropped);
         end else begin
            automatic rsp_type want = expected_status_q.pop_front();
            if (rsp_chan.payload.frame_ready  !== want.frame_ready  ||
                rsp_chan.payload.frame_length !== want.frame_length ||
                rsp_chan.payload.read_data    !== want.read_data    ||
                rsp_chan.payload.byte_dropped !== want.byte_dropped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch word %0d: exp %0b/%0d/%02h/%0b, got %0b/%0d/%02h/%0b",
                           status_seen, want.frame_ready, want.frame_length,
                           want.read_data, want.byte_dropped,
                           rsp_chan.payload.frame_ready, rsp_chan.payload.frame_length,
                           rsp_chan.payload.read_data, rsp_chan.payload.byte_dropped);
            end
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAIL escaped_line_frame_receiver_top");
            $finish;
         end
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      mismatches       = 0;
      words_sent       = 0;
      status_seen      = 0;
      effective_items  = 0;
      frames_closed    = 0;
      frames_filled    = 0;
      bytes_dropped    = 0;
      reads_done       = 0;
      idle_cycles      = 0;

      // directed: reset contents, idle no-ops, escapes, drop while ready
      push_word(OP_READ, 8'hFF, 7'd0, 0, 1);
      push_word(OP_READ, 8'h00, 7'd127, 0, 1);
      push_word(OP_CONSUME, 8'h00, 7'd0, 0, 1);
      push_word(OP_UNUSED, 8'hFF, 7'h7F, 0, 1);
      push_word(OP_RECEIVE, CH_AT, 7'd0, 0, 1);
      push_word(OP_RECEIVE, 8'h00, 7'd0, 0, 1);
      push_word(OP_RECEIVE, 8'hFF, 7'd0, 0, 1);
      push_word(OP_RECEIVE, CH_BACKSLASH, 7'd0, 0, 1);
      push_word(OP_RECEIVE, 8'h78, 7'd0, 0, 1);
      push_word(OP_RECEIVE, CH_BACKSLASH, 7'd0, 0, 1);
      push_word(OP_RECEIVE, CH_BACKSLASH, 7'd0, 0, 1);
      push_word(OP_RECEIVE, CH_BACKSLASH, 7'd0, 0, 1);
      push_word(OP_RECEIVE, CH_LOWER_N, 7'd0, 0, 1);
      push_word(OP_RECEIVE, 8'h55, 7'd0, 0, 1);
      push_word(OP_UNUSED, 8'h00, 7'd0, 0, 1);
      for (int i = 0; i < 6; i++) push_word(OP_READ, 8'h00, 7'(i), 0, 1);
      push_word(OP_CONSUME, 8'h00, 7'd0, 0, 1);
      push_word(OP_RECEIVE, 8'h5A, 7'd0, 0, 1);
      push_word(OP_RECEIVE, CH_CR, 7'd0, 0, 1);
      push_word(OP_CONSUME, 8'h00, 7'd0, 0, 1);
      push_word(OP_RECEIVE, 8'h71, 7'd0, 0, 1);
      push_word(OP_RECEIVE, CH_BACKSLASH, 7'd0, 0, 1);
      push_word(OP_RECEIVE, CH_LOWER_R, 7'd0, 0, 1);
      push_word(OP_READ, 8'h00, 7'd1, 0, 1);
      push_word(OP_CONSUME, 8'h00, 7'd0, 1, 1);

      // frame that fills the store with a backslash pending in the last slot
      push_frame(125, 4, 0);
      push_word(OP_RECEIVE, CH_BACKSLASH, 7'd0, 0, 1);
      push_word(OP_RECEIVE, 8'h78, 7'd0, 0, 1);
      push_word(OP_READ, 8'h00, 7'd126, 0, 1);
      push_word(OP_READ, 8'h00, 7'd127, 0, 1);
      push_word(OP_CONSUME, 8'h00, 7'd0, 0, 1);

      while (effective_items < WORD_TARGET) begin
         if ($urandom_range(0, 99) < 78) begin
            automatic int len = ($urandom_range(0, 11) == 0) ? $urandom_range(118, 135)
                                                             : $urandom_range(0, 10);
            push_word(OP_CONSUME, 8'($urandom), 7'($urandom),
                      ($urandom_range(0, 49) == 0), 1);
            push_frame(len, (len >= 118) ? $urandom_range(0, 4) : $urandom_range(0, 3),
                       $urandom_range(0, 1) ? 8 : 40);
            repeat ($urandom_range(0, 2))
               push_word(OP_READ, 8'($urandom),
                         $urandom_range(0, 1) ? 7'($urandom) : 7'($urandom_range(0, len)),
                         0, 1);
            if ($urandom_range(0, 3) == 0)
               push_word(OP_RECEIVE, 8'($urandom), 7'($urandom), 0, 1);
            if ($urandom_range(0, 7) != 0)
               push_word(OP_CONSUME, 8'($urandom), 7'($urandom), 0, 1);
         end else begin
            repeat ($urandom_range(1, 6))
               push_word(2'($urandom), 8'($urandom), 7'($urandom), 0, 1);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_chan.valid) @(posedge clock);
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      mismatches += expected_status_q.size();

      $display("sent %0d request words, checked %0d responses, %0d mismatches",
               words_sent, status_seen, mismatches);
      $display("frames closed %0d (%0d by store full), bytes dropped %0d, reads %0d",
               frames_closed, frames_filled, bytes_dropped, reads_done);
      if (mismatches == 0 && status_seen == words_sent) begin
         $display("PASS escaped_line_frame_receiver_top");
      end else begin
         $display("FAIL escaped_line_frame_receiver_top");
      end
      $finish;
   end

endmodule
